// File: rtl/fsmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fsmf_pkg: shared types and constants of the frame store median filter
// Frame geometry, field widths, command codes and the queued command word.
// ---------------------------------------------------------------------------
package fsmf_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_RADIUS = 2;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam int X_W    = 6;
  localparam int Y_W    = 6;
  localparam int DIM_W  = 7;
  localparam int RAD_W  = 2;
  localparam int CH_W   = 32;
  localparam int PASS_W = 4;
  localparam int KIND_W = 2;

  localparam int SPAN_MAX  = 2 * MAX_RADIUS + 1;
  localparam int WIN_MAX   = SPAN_MAX * SPAN_MAX;
  localparam int WIN_IDX_W = $clog2(WIN_MAX);
  localparam int WIN_CNT_W = $clog2(WIN_MAX + 1);
  localparam int OFF_W     = $clog2(SPAN_MAX);
  localparam int SX_W      = DIM_W + 2;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 7'd64;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 7'd64;
  localparam logic [RAD_W-1:0] RADIUS_RST = 2'd1;

  localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);
  localparam logic [RAD_W-1:0] MAX_R_RAD = RAD_W'(MAX_RADIUS);

  localparam logic [CH_W-1:0] Q_ONE = 32'h0001_0000;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACC    = 2'd0,
    KIND_MARK   = 2'd1,
    KIND_FILTER = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  localparam int PIX_W = $bits(pix_t);

  typedef struct packed {
    kind_t             kind;
    logic              err;
    logic [ADDR_W-1:0] addr;
    pix_t              add;
    logic [PASS_W-1:0] passes;
  } op_t;

  typedef struct packed {
    logic clearing;
  } eng_stat_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] res;
    if (v == '0) res = DIM_W'(1);
    else if (v > maxv) res = maxv;
    else res = v;
    return res;
  endfunction

  function automatic logic [RAD_W-1:0] eff_rad(input logic [RAD_W-1:0] v);
    return (v > MAX_R_RAD) ? MAX_R_RAD : v;
  endfunction

  function automatic logic [ADDR_W-1:0] pix_addr(input logic [X_W-1:0] x,
                                                 input logic [Y_W-1:0] y);
    return ADDR_W'(ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x));
  endfunction

endpackage
`default_nettype wire

// File: rtl/frame_store_median_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// frame_store_median_filter: RGB frame store with a square median filter
// Pixel accumulate, mark, read and multi-pass median filtering of a frame.
// ---------------------------------------------------------------------------
// Each input word returns exactly one result word. After reset the frame
// memory is swept to zero, one pixel a cycle, and no input word is taken
// during that sweep. Accumulate, mark and read words read the frame memory
// in the back end, then write the pixel back (not for reads) and present
// the result. Words with a coordinate outside the frame and filter words
// with a pass count of zero are answered as they leave the queue. Each pass
// of a filter word copies the frame into the snapshot memory, then for each
// pixel of the in-use frame reads its (2r+1)^2 window, r being the effective
// kernel radius, through the single read port of the snapshot memory, which
// yields one window sample a cycle. A two-entry command queue separates
// acceptance from execution; the result register holds a result while the
// output is stalled, and a word completes only once that register can be loaded.
// Configuration is written through cfg_we/cfg_index/cfg_wdata only while
// the block is idle, a rule for the user that the block does not enforce.
module frame_store_median_filter (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [fsmf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fsmf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [fsmf_pkg::KIND_W-1:0]        in_kind,
  input  wire logic [fsmf_pkg::X_W-1:0]           in_pos_x,
  input  wire logic [fsmf_pkg::Y_W-1:0]           in_pos_y,
  input  wire logic [fsmf_pkg::CH_W-1:0]          in_add_red,
  input  wire logic [fsmf_pkg::CH_W-1:0]          in_add_green,
  input  wire logic [fsmf_pkg::CH_W-1:0]          in_add_blue,
  input  wire logic [fsmf_pkg::PASS_W-1:0]        in_pass_count,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [fsmf_pkg::CH_W-1:0]          out_red,
  output logic      [fsmf_pkg::CH_W-1:0]          out_green,
  output logic      [fsmf_pkg::CH_W-1:0]          out_blue,
  output logic                                    out_coord_error
);

  logic [fsmf_pkg::DIM_W-1:0] width_r;
  logic [fsmf_pkg::DIM_W-1:0] height_r;
  logic [fsmf_pkg::RAD_W-1:0] radius_r;
  logic [fsmf_pkg::DIM_W-1:0] eff_w, eff_h;
  logic [fsmf_pkg::RAD_W-1:0] eff_r;

  fsmf_pkg::op_t       q_din, q_head;
  logic                q_push, q_pop, q_empty, q_full;
  fsmf_pkg::eng_stat_t stat;

  // Configuration registers. Writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= fsmf_pkg::WIDTH_RST;
      height_r <= fsmf_pkg::HEIGHT_RST;
      radius_r <= fsmf_pkg::RADIUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fsmf_pkg::CFG_WIDTH:  width_r  <= cfg_wdata;
        fsmf_pkg::CFG_HEIGHT: height_r <= cfg_wdata;
        fsmf_pkg::CFG_RADIUS: radius_r <= cfg_wdata[fsmf_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range sizes act as the nearest legal value.
  assign eff_w = fsmf_pkg::eff_dim(width_r, fsmf_pkg::MAX_W_DIM);
  assign eff_h = fsmf_pkg::eff_dim(height_r, fsmf_pkg::MAX_H_DIM);
  assign eff_r = fsmf_pkg::eff_rad(radius_r);

  fsmf_front u_front (
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_add_red(in_add_red),
    .in_add_green(in_add_green), .in_add_blue(in_add_blue),
    .in_pass_count(in_pass_count), .eff_w(eff_w), .eff_h(eff_h),
    .stat(stat), .q_full(q_full), .q_push(q_push), .q_din(q_din)
  );

  fsmf_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .din(q_din), .pop(q_pop),
    .head(q_head), .empty(q_empty), .full(q_full)
  );

  fsmf_engine u_engine (
    .clk(clk), .rst_n(rst_n), .head(q_head), .q_empty(q_empty), .q_pop(q_pop),
    .eff_w(eff_w), .eff_h(eff_h), .eff_r(eff_r), .out_valid(out_valid),
    .out_stall(out_stall), .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue), .out_coord_error(out_coord_error), .stat(stat)
  );

  // Nothing may enter while the frame memory is still being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> in_stall) else $error("word accepted during frame clear");

  // A full queue must hold off the input side.
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push) else $error("command queue overflow");

  // A flagged coordinate never carries color data.
  a_err_zero_color: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_coord_error) |->
      (out_red == '0 && out_green == '0 && out_blue == '0))
    else $error("coordinate error with nonzero color");

endmodule
`default_nettype wire

// File: rtl/fsmf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fsmf_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module fsmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/fsmf_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fsmf_fifo: command queue between front and back end
// A short register queue of classified commands.
// ---------------------------------------------------------------------------
module fsmf_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire fsmf_pkg::op_t  din,
  input  wire logic           pop,
  output fsmf_pkg::op_t       head,
  output logic                empty,
  output logic                full
);

  fsmf_pkg::op_t                         q_r [fsmf_pkg::FIFO_DEPTH];
  logic [fsmf_pkg::FIFO_PTR_W-1:0]       wr_ptr_r;
  logic [fsmf_pkg::FIFO_PTR_W-1:0]       rd_ptr_r;
  logic [fsmf_pkg::FIFO_CNT_W-1:0]       cnt_r;

  assign head  = q_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == fsmf_pkg::FIFO_CNT_W'(fsmf_pkg::FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= din;
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/fsmf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fsmf_front: input acceptance and command classification
// Checks coordinates against the frame and forms the queued command word.
// ---------------------------------------------------------------------------
module fsmf_front (
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [fsmf_pkg::KIND_W-1:0]     in_kind,
  input  wire logic [fsmf_pkg::X_W-1:0]        in_pos_x,
  input  wire logic [fsmf_pkg::Y_W-1:0]        in_pos_y,
  input  wire logic [fsmf_pkg::CH_W-1:0]       in_add_red,
  input  wire logic [fsmf_pkg::CH_W-1:0]       in_add_green,
  input  wire logic [fsmf_pkg::CH_W-1:0]       in_add_blue,
  input  wire logic [fsmf_pkg::PASS_W-1:0]     in_pass_count,
  input  wire logic [fsmf_pkg::DIM_W-1:0]      eff_w,
  input  wire logic [fsmf_pkg::DIM_W-1:0]      eff_h,
  input  wire fsmf_pkg::eng_stat_t             stat,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output fsmf_pkg::op_t                        q_din
);

  logic outside;

  assign outside = ({1'b0, in_pos_x} >= eff_w) || ({1'b0, in_pos_y} >= eff_h);

  always_comb begin
    q_din.kind   = fsmf_pkg::kind_t'(in_kind);
    q_din.err    = (fsmf_pkg::kind_t'(in_kind) != fsmf_pkg::KIND_FILTER) && outside;
    q_din.addr   = fsmf_pkg::pix_addr(in_pos_x, in_pos_y);
    q_din.add    = '{red: in_add_red, green: in_add_green, blue: in_add_blue};
    q_din.passes = in_pass_count;
  end

  // No words are taken while the frame is being cleared after reset.
  assign in_stall = q_full || stat.clearing;
  assign q_push   = in_valid && !in_stall;

endmodule
`default_nettype wire

// File: rtl/fsmf_sorter.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fsmf_sorter: insertion sorter for one color channel of a window
// Keeps the samples in ascending order and presents their median.
// ---------------------------------------------------------------------------
module fsmf_sorter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          clr,
  input  wire logic                          ins,
  input  wire logic [fsmf_pkg::CH_W-1:0]     din,
  output logic      [fsmf_pkg::CH_W-1:0]     median
);

  logic [fsmf_pkg::CH_W-1:0]      v_r   [fsmf_pkg::WIN_MAX];
  logic [fsmf_pkg::CH_W-1:0]      v_nxt [fsmf_pkg::WIN_MAX];
  logic [fsmf_pkg::WIN_MAX-1:0]   gtx;
  logic [fsmf_pkg::WIN_CNT_W-1:0] n_r;
  logic [fsmf_pkg::WIN_CNT_W-1:0] half;
  logic [fsmf_pkg::WIN_IDX_W-1:0] hi_idx;
  logic [fsmf_pkg::WIN_IDX_W-1:0] lo_idx;
  logic [fsmf_pkg::CH_W:0]        sum;

  // A cell moves up when it holds a larger value or is still empty.
  always_comb begin
    for (int i = 0; i < fsmf_pkg::WIN_MAX; i++) begin
      gtx[i] = (fsmf_pkg::WIN_CNT_W'(i) >= n_r) || (v_r[i] > din);
    end
    v_nxt[0] = gtx[0] ? din : v_r[0];
    for (int i = 1; i < fsmf_pkg::WIN_MAX; i++) begin
      if (!gtx[i]) v_nxt[i] = v_r[i];
      else if (gtx[i-1]) v_nxt[i] = v_r[i-1];
      else v_nxt[i] = din;
    end
  end

  assign half   = n_r >> 1;
  assign hi_idx = half[fsmf_pkg::WIN_IDX_W-1:0];
  assign lo_idx = (hi_idx == '0) ? hi_idx : hi_idx - 1'b1;
  assign sum    = {1'b0, v_r[hi_idx]} + {1'b0, v_r[lo_idx]};
  assign median = n_r[0] ? v_r[hi_idx] : sum[fsmf_pkg::CH_W:1];

  always_ff @(posedge clk) begin
    if (ins) v_r <= v_nxt;
    if (!rst_n) begin
      n_r <= '0;
    end else if (clr) begin
      n_r <= '0;
    end else if (ins) begin
      n_r <= n_r + 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/fsmf_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fsmf_engine: back end that executes queued commands
// Owns the frame and snapshot memories, clears the frame after reset,
// performs pixel updates and reads, and runs the median filter passes.
// ---------------------------------------------------------------------------
module fsmf_engine (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fsmf_pkg::op_t                 head,
  input  wire logic                          q_empty,
  output logic                               q_pop,
  input  wire logic [fsmf_pkg::DIM_W-1:0]    eff_w,
  input  wire logic [fsmf_pkg::DIM_W-1:0]    eff_h,
  input  wire logic [fsmf_pkg::RAD_W-1:0]    eff_r,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [fsmf_pkg::CH_W-1:0]     out_red,
  output logic      [fsmf_pkg::CH_W-1:0]     out_green,
  output logic      [fsmf_pkg::CH_W-1:0]     out_blue,
  output logic                               out_coord_error,
  output fsmf_pkg::eng_stat_t                stat
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_PIX, ST_COPY, ST_WIN, ST_TAIL, ST_MED, ST_DONE
  } state_t;

  state_t                           state_r;
  logic [fsmf_pkg::ADDR_W-1:0]      clr_addr_r;
  logic [fsmf_pkg::ADDR_W:0]        cp_r;
  fsmf_pkg::op_t                    cur_r;
  logic [fsmf_pkg::PASS_W-1:0]      passes_r;
  logic [fsmf_pkg::X_W-1:0]         x_r;
  logic [fsmf_pkg::Y_W-1:0]         y_r;
  logic [fsmf_pkg::OFF_W-1:0]       ox_r;
  logic [fsmf_pkg::OFF_W-1:0]       oy_r;
  logic                             smp_v_r;
  logic                             out_valid_r;
  logic                             out_valid_nxt;
  logic [fsmf_pkg::CH_W-1:0]        out_red_r;
  logic [fsmf_pkg::CH_W-1:0]        out_green_r;
  logic [fsmf_pkg::CH_W-1:0]        out_blue_r;
  logic                             out_err_r;

  logic                             pix_we, pix_re, snap_we, snap_re;
  logic [fsmf_pkg::ADDR_W-1:0]      pix_waddr, pix_raddr, snap_waddr, snap_raddr;
  fsmf_pkg::pix_t                   pix_wdata, pix_rdata, snap_rdata;
  fsmf_pkg::pix_t                   upd;
  logic                             out_free;
  logic                             needs_exec;
  logic [fsmf_pkg::OFF_W-1:0]       span;
  logic [fsmf_pkg::SX_W-1:0]        sx, sy;
  logic                             in_win;
  logic                             last_x, last_y;
  logic                             srt_clr, srt_ins;
  logic [fsmf_pkg::CH_W-1:0]        med_r, med_g, med_b;

  function automatic logic [fsmf_pkg::CH_W-1:0] sat_add(
      input logic [fsmf_pkg::CH_W-1:0] a, input logic [fsmf_pkg::CH_W-1:0] b);
    logic [fsmf_pkg::CH_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[fsmf_pkg::CH_W] ? '1 : s[fsmf_pkg::CH_W-1:0];
  endfunction

  assign out_free   = !out_valid_r || !out_stall;
  assign needs_exec = (head.kind == fsmf_pkg::KIND_FILTER) ? (head.passes != '0) : !head.err;
  assign q_pop      = (state_r == ST_IDLE) && !q_empty && (needs_exec || out_free);

  // A result is held while stalled and loaded whenever a word completes.
  assign out_valid_nxt = (out_valid_r && out_stall) || (q_pop && !needs_exec)
                      || (((state_r == ST_PIX) || (state_r == ST_DONE)) && out_free);

  // Window sample position relative to the pixel being filtered.
  assign span   = fsmf_pkg::OFF_W'({eff_r, 1'b0});
  assign sx     = fsmf_pkg::SX_W'(x_r) + fsmf_pkg::SX_W'(ox_r) - fsmf_pkg::SX_W'(eff_r);
  assign sy     = fsmf_pkg::SX_W'(y_r) + fsmf_pkg::SX_W'(oy_r) - fsmf_pkg::SX_W'(eff_r);
  assign in_win = !sx[fsmf_pkg::SX_W-1] && !sy[fsmf_pkg::SX_W-1]
               && (sx[fsmf_pkg::SX_W-2:0] < (fsmf_pkg::SX_W-1)'(eff_w))
               && (sy[fsmf_pkg::SX_W-2:0] < (fsmf_pkg::SX_W-1)'(eff_h));
  assign last_x = ({1'b0, x_r} == eff_w - 1'b1);
  assign last_y = ({1'b0, y_r} == eff_h - 1'b1);

  always_comb begin
    upd = pix_rdata;
    case (cur_r.kind)
      fsmf_pkg::KIND_ACC: begin
        upd.red   = sat_add(pix_rdata.red,   cur_r.add.red);
        upd.green = sat_add(pix_rdata.green, cur_r.add.green);
        upd.blue  = sat_add(pix_rdata.blue,  cur_r.add.blue);
      end
      fsmf_pkg::KIND_MARK: begin
        upd = '{red: fsmf_pkg::Q_ONE, green: '0, blue: fsmf_pkg::Q_ONE};
      end
      default: upd = pix_rdata;
    endcase
  end

  always_comb begin
    pix_we     = 1'b0;
    pix_waddr  = fsmf_pkg::pix_addr(x_r, y_r);
    pix_wdata  = '{red: med_r, green: med_g, blue: med_b};
    pix_re     = 1'b0;
    pix_raddr  = head.addr;
    snap_we    = 1'b0;
    snap_waddr = cp_r[fsmf_pkg::ADDR_W-1:0] - 1'b1;
    snap_re    = 1'b0;
    snap_raddr = fsmf_pkg::pix_addr(sx[fsmf_pkg::X_W-1:0], sy[fsmf_pkg::Y_W-1:0]);
    unique case (state_r)
      ST_CLEAR: begin
        pix_we    = 1'b1;
        pix_waddr = clr_addr_r;
        pix_wdata = '0;
      end
      ST_IDLE: begin
        pix_re = !q_empty && (head.kind != fsmf_pkg::KIND_FILTER) && !head.err;
      end
      ST_PIX: begin
        pix_we    = out_free && (cur_r.kind != fsmf_pkg::KIND_READ);
        pix_waddr = cur_r.addr;
        pix_wdata = upd;
      end
      ST_COPY: begin
        pix_re    = !cp_r[fsmf_pkg::ADDR_W];
        pix_raddr = cp_r[fsmf_pkg::ADDR_W-1:0];
        snap_we   = (cp_r != '0);
      end
      ST_WIN:  snap_re = in_win;
      ST_MED:  pix_we = 1'b1;
      default: pix_we = 1'b0;
    endcase
  end

  assign srt_ins = smp_v_r && ((state_r == ST_WIN) || (state_r == ST_TAIL));
  assign srt_clr = (state_r == ST_MED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      smp_v_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == fsmf_pkg::ADDR_W'(fsmf_pkg::DEPTH - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_pop) begin
            cur_r <= head;
            if (needs_exec) begin
              if (head.kind == fsmf_pkg::KIND_FILTER) begin
                passes_r <= head.passes;
                cp_r     <= '0;
                state_r  <= ST_COPY;
              end else begin
                state_r <= ST_PIX;
              end
            end else begin
              out_red_r   <= '0;
              out_green_r <= '0;
              out_blue_r  <= '0;
              out_err_r   <= head.err;
            end
          end
        end
        ST_PIX: begin
          if (out_free) begin
            out_err_r   <= 1'b0;
            if (cur_r.kind == fsmf_pkg::KIND_READ) begin
              out_red_r   <= pix_rdata.red;
              out_green_r <= pix_rdata.green;
              out_blue_r  <= pix_rdata.blue;
            end else begin
              out_red_r   <= '0;
              out_green_r <= '0;
              out_blue_r  <= '0;
            end
            state_r <= ST_IDLE;
          end
        end
        ST_COPY: begin
          cp_r <= cp_r + 1'b1;
          if (cp_r[fsmf_pkg::ADDR_W]) begin
            x_r     <= '0;
            y_r     <= '0;
            ox_r    <= '0;
            oy_r    <= '0;
            state_r <= ST_WIN;
          end
        end
        ST_WIN: begin
          smp_v_r <= in_win;
          if (ox_r == span) begin
            ox_r <= '0;
            if (oy_r == span) begin
              oy_r    <= '0;
              state_r <= ST_TAIL;
            end else begin
              oy_r <= oy_r + 1'b1;
            end
          end else begin
            ox_r <= ox_r + 1'b1;
          end
        end
        ST_TAIL: begin
          smp_v_r <= 1'b0;
          state_r <= ST_MED;
        end
        ST_MED: begin
          if (last_x) begin
            x_r <= '0;
            if (last_y) begin
              y_r      <= '0;
              passes_r <= passes_r - 1'b1;
              cp_r     <= '0;
              state_r  <= (passes_r == fsmf_pkg::PASS_W'(1)) ? ST_DONE : ST_COPY;
            end else begin
              y_r     <= y_r + 1'b1;
              state_r <= ST_WIN;
            end
          end else begin
            x_r     <= x_r + 1'b1;
            state_r <= ST_WIN;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_red_r   <= '0;
            out_green_r <= '0;
            out_blue_r  <= '0;
            out_err_r   <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  fsmf_ram #(.WIDTH(fsmf_pkg::PIX_W), .DEPTH(fsmf_pkg::DEPTH)) u_pix_ram (
    .clk(clk), .we(pix_we), .waddr(pix_waddr), .wdata(pix_wdata),
    .re(pix_re), .raddr(pix_raddr), .rdata(pix_rdata)
  );

  fsmf_ram #(.WIDTH(fsmf_pkg::PIX_W), .DEPTH(fsmf_pkg::DEPTH)) u_snap_ram (
    .clk(clk), .we(snap_we), .waddr(snap_waddr), .wdata(pix_rdata),
    .re(snap_re), .raddr(snap_raddr), .rdata(snap_rdata)
  );

  fsmf_sorter u_sort_r (.clk(clk), .rst_n(rst_n), .clr(srt_clr), .ins(srt_ins),
                        .din(snap_rdata.red), .median(med_r));
  fsmf_sorter u_sort_g (.clk(clk), .rst_n(rst_n), .clr(srt_clr), .ins(srt_ins),
                        .din(snap_rdata.green), .median(med_g));
  fsmf_sorter u_sort_b (.clk(clk), .rst_n(rst_n), .clr(srt_clr), .ins(srt_ins),
                        .din(snap_rdata.blue), .median(med_b));

  assign out_valid       = out_valid_r;
  assign out_red         = out_red_r;
  assign out_green       = out_green_r;
  assign out_blue        = out_blue_r;
  assign out_coord_error = out_err_r;
  assign stat.clearing   = (state_r == ST_CLEAR);

endmodule
`default_nettype wire
